// ----- rtl/gti_pkg.sv -----
package gti_pkg;

    localparam int InW   = 32;
    localparam int OutW  = 64;
    localparam int SymW  = 33;
    localparam int ProdW = 66;
    localparam int AccW  = 72;
    localparam int QuadW = 148;

    // wide operands are cut into a low and a high half of this width
    localparam int LimbW = 35;

    localparam int ShQg = 21;
    localparam int ShQs = 23;
    localparam int ShRg = 50;
    localparam int ShRs = 53;
    localparam int ShV  = 83;

    localparam int InDataW  = 9 * InW;
    localparam int OutDataW = 5 * OutW;

    typedef struct packed {
        logic [OutW-1:0] value;
        logic            clip;
    } sat_t;

    // round to nearest with ties up, then clip to the signed output range
    function automatic sat_t round_sat(input logic signed [QuadW-1:0] x, input int sh);
        logic signed [QuadW-1:0] half;
        logic signed [QuadW-1:0] sum;
        logic signed [QuadW-1:0] shifted;
        logic signed [QuadW-1:0] lim;
        sat_t r;
        half    = '0;
        half[sh-1] = 1'b1;
        sum     = x + half;
        shifted = sum >>> sh;
        lim     = {{(QuadW-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
        r.clip  = 1'b0;
        r.value = shifted[OutW-1:0];
        if (shifted > lim) begin
            r.clip  = 1'b1;
            r.value = {1'b0, {(OutW-1){1'b1}}};
        end else if (shifted < ~lim) begin
            r.clip  = 1'b1;
            r.value = {1'b1, {(OutW-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/gti_stage.sv -----
module gti_stage #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic         valid_reg;
    logic [W-1:0] data_reg;

    // pipeline register, advances when downstream slot frees
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end
endmodule

// ----- rtl/gradient_tensor_invariants_core.sv -----
// Velocity-gradient tensor invariants, one 3x3 tensor per item.
// Input channel s_axis: nine signed Q2.30 elements g00..g22 in s_axis_tdata.
// Output channel m_axis: QG, QS, RG, RS, V2 as signed 64-bit values with
// 40 fractional bits, plus a saturation flag in m_axis_tuser.
// The datapath is a seven-stage pipeline: symmetric/antisymmetric split,
// pairwise products, row sums, invariant squares and partial products,
// partial product merge, final sums, then rounding and saturation.
// m_axis_tvalid rises once an accepted item has passed through every stage
// register; while the receiver does not stall, throughput is one item per cycle,
// set by the fact that every stage holds exactly one item and each
// multiplier is its own unit.
// Operands wider than 35 bits are cut into two halves; their partial
// products are formed in one stage and merged in the next.
// When the receiver stalls, occupied stages hold, and s_axis_tready drops once
// the pipe is full; no item is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the data registers
// are not reset.
module gradient_tensor_invariants_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [gti_pkg::InDataW-1:0] s_axis_tdata,  // g00 g01 g02 g10 g11 g12 g20 g21 g22
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [gti_pkg::OutDataW-1:0] m_axis_tdata, // q_grad q_strain r_grad r_strain v_two
    output logic [0:0]  m_axis_tuser                   // saturated
);
    import gti_pkg::*;

    typedef logic signed [SymW-1:0]  sym_t;
    typedef logic signed [ProdW-1:0] prod_t;
    typedef logic signed [AccW-1:0]  acc_t;
    typedef logic signed [QuadW-1:0] quad_t;
    typedef logic signed [LimbW:0]   lo_t;
    typedef logic signed [LimbW-1:0] hi_t;

    localparam int S1W = 9 * InW + 9 * SymW * 2;
    localparam int S2W = InDataW + 9 * SymW + 87 * ProdW;

    // low half of a wide value, zero-extended
    function automatic lo_t lo_part(input acc_t x);
        return $signed({1'b0, x[LimbW-1:0]});
    endfunction

    // high half of a wide value, carries the sign
    function automatic hi_t hi_part(input acc_t x);
        return $signed(x[2*LimbW-1:LimbW]);
    endfunction

    // ---------------- stage 1: split into A = 2S and B = 2O
    logic signed [InW-1:0] g_in [3][3];
    sym_t a_c [3][3];
    sym_t b_c [3][3];
    logic [S1W-1:0] s1_d, s1_q;
    logic s1_v, s1_r;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                g_in[i][j] = s_axis_tdata[(i*3+j)*InW +: InW];
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a_c[i][j] = SymW'(g_in[i][j]) + SymW'(g_in[j][i]);
                b_c[i][j] = SymW'(g_in[i][j]) - SymW'(g_in[j][i]);
            end
        end
        s1_d = '0;
        s1_d[InDataW-1:0] = s_axis_tdata;
        for (int k = 0; k < 9; k++) begin
            s1_d[InDataW + k*SymW +: SymW]          = a_c[k/3][k%3];
            s1_d[InDataW + (9+k)*SymW +: SymW]      = b_c[k/3][k%3];
        end
    end

    gti_stage #(.W(S1W)) u_st1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s1_d),
        .out_valid(s1_v), .out_ready(s1_r), .out_data(s1_q)
    );

    // ---------------- stage 2: first-level products
    logic signed [InW-1:0] g1 [3][3];
    sym_t a1 [3][3];
    sym_t b1 [3][3];
    prod_t gg [3][3][3];   // g[i][k]*g[k][j]
    prod_t aa [3][3][3];
    prod_t bb [3][3][3];
    prod_t cof [3];        // minors of G for row 0
    prod_t acof [3];
    logic [S2W-1:0] s2_d, s2_q;
    logic s2_v, s2_r;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            g1[k/3][k%3] = s1_q[k*InW +: InW];
            a1[k/3][k%3] = s1_q[InDataW + k*SymW +: SymW];
            b1[k/3][k%3] = s1_q[InDataW + (9+k)*SymW +: SymW];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    gg[i][j][k] = ProdW'(g1[i][k]) * ProdW'(g1[k][j]);
                    aa[i][j][k] = ProdW'(a1[i][k]) * ProdW'(a1[k][j]);
                    bb[i][j][k] = ProdW'(b1[i][k]) * ProdW'(b1[k][j]);
                end
            end
        end
        cof[0]  = ProdW'(g1[1][1]) * ProdW'(g1[2][2]) - ProdW'(g1[1][2]) * ProdW'(g1[2][1]);
        cof[1]  = ProdW'(g1[1][0]) * ProdW'(g1[2][2]) - ProdW'(g1[1][2]) * ProdW'(g1[2][0]);
        cof[2]  = ProdW'(g1[1][0]) * ProdW'(g1[2][1]) - ProdW'(g1[1][1]) * ProdW'(g1[2][0]);
        acof[0] = ProdW'(a1[1][1]) * ProdW'(a1[2][2]) - ProdW'(a1[1][2]) * ProdW'(a1[2][1]);
        acof[1] = ProdW'(a1[1][0]) * ProdW'(a1[2][2]) - ProdW'(a1[1][2]) * ProdW'(a1[2][0]);
        acof[2] = ProdW'(a1[1][0]) * ProdW'(a1[2][1]) - ProdW'(a1[1][1]) * ProdW'(a1[2][0]);
        s2_d = '0;
        s2_d[InDataW + 9*SymW - 1:0] = s1_q[InDataW + 9*SymW - 1:0];
        for (int k = 0; k < 27; k++) begin
            s2_d[InDataW + 9*SymW + k*ProdW +: ProdW] = gg[k/9][(k/3)%3][k%3];
        end
        // only diagonal of G^2 and A^2 matters for traces; keep full A^2, B^2
        for (int k = 0; k < 27; k++) begin
            s2_d[InDataW + 9*SymW + (27+k)*ProdW +: ProdW] = aa[k/9][(k/3)%3][k%3];
        end
        for (int k = 0; k < 27; k++) begin
            s2_d[InDataW + 9*SymW + (54+k)*ProdW +: ProdW] = bb[k/9][(k/3)%3][k%3];
        end
        for (int k = 0; k < 3; k++) begin
            s2_d[InDataW + 9*SymW + (81+k)*ProdW +: ProdW] = cof[k];
            s2_d[InDataW + 9*SymW + (84+k)*ProdW +: ProdW] = acof[k];
        end
    end

    gti_stage #(.W(S2W)) u_st2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s1_v), .in_ready(s1_r), .in_data(s2_d),
        .out_valid(s2_v), .out_ready(s2_r), .out_data(s2_q)
    );

    // ---------------- stage 3: sums of products
    logic signed [InW-1:0] g2 [3][3];
    sym_t a2s [3][3];
    acc_t a2m [3][3];
    acc_t b2m [3][3];
    acc_t tr_g, tr_g2, tr_a, tr_a2, tr_b2;
    acc_t cf [3];
    acc_t acf [3];
    localparam int S3X = InDataW + 9*SymW + 18*AccW + 5*AccW + 6*AccW;
    logic [S3X-1:0] s3_d, s3_q;
    logic s3_v, s3_r;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            g2[k/3][k%3]  = s2_q[k*InW +: InW];
            a2s[k/3][k%3] = s2_q[InDataW + k*SymW +: SymW];
        end
        tr_g  = AccW'(g2[0][0]) + AccW'(g2[1][1]) + AccW'(g2[2][2]);
        tr_a  = AccW'(a2s[0][0]) + AccW'(a2s[1][1]) + AccW'(a2s[2][2]);
        tr_g2 = '0;
        tr_a2 = '0;
        tr_b2 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a2m[i][j] = '0;
                b2m[i][j] = '0;
                for (int k = 0; k < 3; k++) begin
                    a2m[i][j] = a2m[i][j] + AccW'($signed(
                        s2_q[InDataW + 9*SymW + (27 + i*9 + j*3 + k)*ProdW +: ProdW]));
                    b2m[i][j] = b2m[i][j] + AccW'($signed(
                        s2_q[InDataW + 9*SymW + (54 + i*9 + j*3 + k)*ProdW +: ProdW]));
                end
            end
            for (int k = 0; k < 3; k++) begin
                tr_g2 = tr_g2 + AccW'($signed(
                    s2_q[InDataW + 9*SymW + (i*9 + i*3 + k)*ProdW +: ProdW]));
            end
            tr_a2 = tr_a2 + a2m[i][i];
            tr_b2 = tr_b2 + b2m[i][i];
        end
        for (int k = 0; k < 3; k++) begin
            cf[k]  = AccW'($signed(s2_q[InDataW + 9*SymW + (81+k)*ProdW +: ProdW]));
            acf[k] = AccW'($signed(s2_q[InDataW + 9*SymW + (84+k)*ProdW +: ProdW]));
        end
        s3_d = '0;
        s3_d[InDataW + 9*SymW - 1:0] = s2_q[InDataW + 9*SymW - 1:0];
        for (int k = 0; k < 9; k++) begin
            s3_d[InDataW + 9*SymW + k*AccW +: AccW]     = a2m[k/3][k%3];
            s3_d[InDataW + 9*SymW + (9+k)*AccW +: AccW] = b2m[k/3][k%3];
        end
        s3_d[InDataW + 9*SymW + 18*AccW +: AccW] = tr_g;
        s3_d[InDataW + 9*SymW + 19*AccW +: AccW] = tr_g2;
        s3_d[InDataW + 9*SymW + 20*AccW +: AccW] = tr_a;
        s3_d[InDataW + 9*SymW + 21*AccW +: AccW] = tr_a2;
        s3_d[InDataW + 9*SymW + 22*AccW +: AccW] = tr_b2;
        for (int k = 0; k < 3; k++) begin
            s3_d[InDataW + 9*SymW + (23+k)*AccW +: AccW] = cf[k];
            s3_d[InDataW + 9*SymW + (26+k)*AccW +: AccW] = acf[k];
        end
    end

    gti_stage #(.W(S3X)) u_st3 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s2_v), .in_ready(s2_r), .in_data(s3_d),
        .out_valid(s3_v), .out_ready(s3_r), .out_data(s3_q)
    );

    // ---------------- stage 4: invariant squares and partial products
    // slots: qg2, qs8, trb, six for RG, six for RS, four per A^2 B^2 term
    localparam int S4X = 51 * AccW;
    logic [S4X-1:0] s4_d, s4_q;
    logic s4_v, s4_r;

    always_comb begin
        acc_t t_g2, t_a2, x, y;
        logic signed [InW+1:0]  tg_n;
        logic signed [SymW+1:0] ta_n;
        logic signed [InW-1:0]  gr;
        sym_t ar;
        s4_d = '0;
        tg_n = s3_q[InDataW + 9*SymW + 18*AccW +: InW+2];
        t_g2 = $signed(s3_q[InDataW + 9*SymW + 19*AccW +: AccW]);
        ta_n = s3_q[InDataW + 9*SymW + 20*AccW +: SymW+2];
        t_a2 = $signed(s3_q[InDataW + 9*SymW + 21*AccW +: AccW]);
        s4_d[0*AccW +: AccW] = tg_n * tg_n - t_g2;
        s4_d[1*AccW +: AccW] = ta_n * ta_n - t_a2;
        s4_d[2*AccW +: AccW] = s3_q[InDataW + 9*SymW + 22*AccW +: AccW];
        // determinant terms, cofactor cut in halves
        for (int k = 0; k < 3; k++) begin
            gr = s3_q[k*InW +: InW];
            x  = $signed(s3_q[InDataW + 9*SymW + (23+k)*AccW +: AccW]);
            s4_d[(3+2*k)*AccW +: AccW] = gr * lo_part(x);
            s4_d[(4+2*k)*AccW +: AccW] = gr * hi_part(x);
            ar = s3_q[InDataW + k*SymW +: SymW];
            y  = $signed(s3_q[InDataW + 9*SymW + (26+k)*AccW +: AccW]);
            s4_d[(9+2*k)*AccW +: AccW]  = ar * lo_part(y);
            s4_d[(10+2*k)*AccW +: AccW] = ar * hi_part(y);
        end
        // A^2[i][j] * B^2[j][i], four half products each
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                x = $signed(s3_q[InDataW + 9*SymW + (i*3+j)*AccW +: AccW]);
                y = $signed(s3_q[InDataW + 9*SymW + (9+j*3+i)*AccW +: AccW]);
                s4_d[(15+4*(i*3+j))*AccW +: AccW] = lo_part(x) * lo_part(y);
                s4_d[(16+4*(i*3+j))*AccW +: AccW] = lo_part(x) * hi_part(y);
                s4_d[(17+4*(i*3+j))*AccW +: AccW] = hi_part(x) * lo_part(y);
                s4_d[(18+4*(i*3+j))*AccW +: AccW] = hi_part(x) * hi_part(y);
            end
        end
    end

    gti_stage #(.W(S4X)) u_st4 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s3_v), .in_ready(s3_r), .in_data(s4_d),
        .out_valid(s4_v), .out_ready(s4_r), .out_data(s4_q)
    );

    // ---------------- stage 5: merge partial products, split QS*tr(B^2)
    // narrow slots: qg2, qs8, four halves of qs8*trb; wide: RG, RS, nine terms
    localparam int S5X = 6 * AccW + 11 * QuadW;
    logic [S5X-1:0] s5_d, s5_q;
    logic s5_v, s5_r;

    always_comb begin
        acc_t qs8, trb;
        quad_t rg, rs, t, ll, mid, hh;
        s5_d = '0;
        s5_d[0 +: 2*AccW] = s4_q[0 +: 2*AccW];
        qs8 = $signed(s4_q[1*AccW +: AccW]);
        trb = $signed(s4_q[2*AccW +: AccW]);
        s5_d[2*AccW +: AccW] = lo_part(qs8) * lo_part(trb);
        s5_d[3*AccW +: AccW] = lo_part(qs8) * hi_part(trb);
        s5_d[4*AccW +: AccW] = hi_part(qs8) * lo_part(trb);
        s5_d[5*AccW +: AccW] = hi_part(qs8) * hi_part(trb);
        rg = '0;
        rs = '0;
        for (int k = 0; k < 3; k++) begin
            t = QuadW'($signed(s4_q[(3+2*k)*AccW +: AccW]))
              + (QuadW'($signed(s4_q[(4+2*k)*AccW +: AccW])) <<< LimbW);
            if (k == 1) begin
                rg = rg - t;
            end else begin
                rg = rg + t;
            end
            t = QuadW'($signed(s4_q[(9+2*k)*AccW +: AccW]))
              + (QuadW'($signed(s4_q[(10+2*k)*AccW +: AccW])) <<< LimbW);
            if (k == 1) begin
                rs = rs - t;
            end else begin
                rs = rs + t;
            end
        end
        s5_d[6*AccW + 0*QuadW +: QuadW] = rg;
        s5_d[6*AccW + 1*QuadW +: QuadW] = rs;
        for (int p = 0; p < 9; p++) begin
            ll  = QuadW'($signed(s4_q[(15+4*p)*AccW +: AccW]));
            mid = QuadW'($signed(s4_q[(16+4*p)*AccW +: AccW]))
                + QuadW'($signed(s4_q[(17+4*p)*AccW +: AccW]));
            hh  = QuadW'($signed(s4_q[(18+4*p)*AccW +: AccW]));
            s5_d[6*AccW + (2+p)*QuadW +: QuadW] = ll + (mid <<< LimbW) + (hh <<< (2*LimbW));
        end
    end

    gti_stage #(.W(S5X)) u_st5 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s4_v), .in_ready(s4_r), .in_data(s5_d),
        .out_valid(s5_v), .out_ready(s5_r), .out_data(s5_q)
    );

    // ---------------- stage 6: V2 assembly, other four invariants passed on
    localparam int S6X = 5 * QuadW;
    logic [S6X-1:0] s6_d, s6_q;
    logic s6_v, s6_r;

    always_comb begin
        quad_t tab, mid, vq;
        s6_d = '0;
        s6_d[0*QuadW +: QuadW] = QuadW'($signed(s5_q[0*AccW +: AccW]));
        s6_d[1*QuadW +: QuadW] = QuadW'($signed(s5_q[1*AccW +: AccW]));
        s6_d[2*QuadW +: QuadW] = s5_q[6*AccW + 0*QuadW +: QuadW];
        s6_d[3*QuadW +: QuadW] = s5_q[6*AccW + 1*QuadW +: QuadW];
        tab = '0;
        for (int p = 0; p < 9; p++) begin
            tab = tab + $signed(s5_q[6*AccW + (2+p)*QuadW +: QuadW]);
        end
        mid = QuadW'($signed(s5_q[3*AccW +: AccW])) + QuadW'($signed(s5_q[4*AccW +: AccW]));
        vq  = QuadW'($signed(s5_q[2*AccW +: AccW])) + (mid <<< LimbW)
            + (QuadW'($signed(s5_q[5*AccW +: AccW])) <<< (2*LimbW));
        s6_d[4*QuadW +: QuadW] = tab + tab + vq;
    end

    gti_stage #(.W(S6X)) u_st6 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s5_v), .in_ready(s5_r), .in_data(s6_d),
        .out_valid(s6_v), .out_ready(s6_r), .out_data(s6_q)
    );

    // ---------------- stage 7: round and saturate
    localparam int S7X = OutDataW + 1;
    logic [S7X-1:0] s7_d, s7_q;
    always_comb begin
        sat_t r0, r1, r2, r3, r4;
        r0 = round_sat($signed(s6_q[0*QuadW +: QuadW]), ShQg);
        r1 = round_sat($signed(s6_q[1*QuadW +: QuadW]), ShQs);
        r2 = round_sat($signed(s6_q[2*QuadW +: QuadW]), ShRg);
        r3 = round_sat($signed(s6_q[3*QuadW +: QuadW]), ShRs);
        r4 = round_sat($signed(s6_q[4*QuadW +: QuadW]), ShV);
        s7_d = {r0.clip | r1.clip | r2.clip | r3.clip | r4.clip,
                r4.value, r3.value, r2.value, r1.value, r0.value};
    end

    gti_stage #(.W(S7X)) u_st7 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s6_v), .in_ready(s6_r), .in_data(s7_d),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(s7_q)
    );

    assign m_axis_tdata = s7_q[OutDataW-1:0];
    assign m_axis_tuser = s7_q[OutDataW];
endmodule
